[src/task_round_robin_scheduler_unit_defines.svh]
// assertion macros for the round robin scheduler unit
`ifndef TASK_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH
`define TASK_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH

// property must hold on every clock edge outside reset
`define TRRS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define TRRS_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error(msg);

`endif

[src/trrs_pkg.sv]
// ----------------------------------------------------------------------------
// trrs_pkg
// shared constants, codes, types and helpers of the round robin scheduler
// ----------------------------------------------------------------------------
package trrs_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int OP_W      = 3;
  localparam int CTX_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int TASK_W    = 5;
  localparam int MASK_W    = 16;
  localparam int PAD_W     = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_SCHED  = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
  localparam logic [OP_W-1:0] OP_EXIT   = 3'd2;
  localparam logic [OP_W-1:0] OP_REAP   = 3'd3;
  localparam logic [OP_W-1:0] OP_START  = 3'd4;

  // slot states
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DEAD  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_READY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_HALTED   = 2'd3;

  localparam logic [TASK_W-1:0] TASK_NONE = 5'h1f;

  typedef logic [1:0]        slot_st_t;
  typedef logic [SLOT_W-1:0] slot_idx_t;

  // slot search results handed from the picker to the control
  typedef struct packed {
    logic                 free_found;
    slot_idx_t            free_idx;
    logic                 ready_found;
    slot_idx_t            ready_idx;
    logic [NUM_SLOTS-1:0] reap_vec;
  } pick_t;

  // slot index as the 5-bit task slot, all ones for no task
  function automatic logic [TASK_W-1:0] to_task_slot(input logic vld, input slot_idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return vld ? wide[TASK_W-1:0] : TASK_NONE;
  endfunction

endpackage

[src/trrs_req_if.sv]
// ----------------------------------------------------------------------------
// trrs_req_if
// request channel: operation and context pointer
// ----------------------------------------------------------------------------
interface trrs_req_if;
  import trrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [CTX_W-1:0] context_req;

  modport source (output valid, output op, output context_req, input ready);
  modport sink (input valid, input op, input context_req, output ready);
endinterface

[src/trrs_rsp_if.sv]
// ----------------------------------------------------------------------------
// trrs_rsp_if
// response channel: status, resume context, task slot, freed mask
// ----------------------------------------------------------------------------
interface trrs_rsp_if;
  import trrs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [CTX_W-1:0]           resume_context;
  logic signed [TASK_W-1:0]   task_slot;
  logic [MASK_W-1:0]          freed_mask;

  modport source (
    output valid, output status, output resume_context, output task_slot,
    output freed_mask, input ready
  );
  modport sink (
    input valid, input status, input resume_context, input task_slot,
    input freed_mask, output ready
  );
endinterface

[src/trrs_ctx_ram.sv]
// ----------------------------------------------------------------------------
// trrs_ctx_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module trrs_ctx_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/trrs_picker.sv]
// ----------------------------------------------------------------------------
// trrs_picker
// slot table search: lowest free slot, round robin ready slot, reap set
// ----------------------------------------------------------------------------
module trrs_picker (
  input  trrs_pkg::slot_st_t  st [trrs_pkg::NUM_SLOTS],
  input  logic                run_valid,
  input  trrs_pkg::slot_idx_t run_idx,
  input  logic                incl_cur,
  output trrs_pkg::pick_t     pick
);
  import trrs_pkg::*;

  logic [NUM_SLOTS-1:0]   ready_vec;
  logic [NUM_SLOTS-1:0]   free_vec;
  logic [NUM_SLOTS-1:0]   reap_vec;
  logic [2*NUM_SLOTS-1:0] rot;
  logic [SLOT_W:0]        start_ext;
  slot_idx_t              start;
  slot_idx_t              off;
  logic [SLOT_W:0]        idx_ext;
  logic                   ready_found;
  slot_idx_t              ready_idx;
  logic                   free_found;
  slot_idx_t              free_idx;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ready_vec[i] = (st[i] == ST_READY) ||
                     (incl_cur && run_valid && run_idx == SLOT_W'(i) && st[i] == ST_RUN);
      free_vec[i]  = (st[i] == ST_FREE);
      reap_vec[i]  = (st[i] == ST_DEAD) && !(run_valid && run_idx == SLOT_W'(i));
    end
  end

  // search starts one past the running slot, wrapping
  always_comb begin
    start_ext = {1'b0, run_idx} + (SLOT_W+1)'(1);
    if (!run_valid || start_ext == (SLOT_W+1)'(NUM_SLOTS)) begin
      start = '0;
    end else begin
      start = start_ext[SLOT_W-1:0];
    end
  end

  always_comb begin
    rot = {ready_vec, ready_vec} >> start;
    off = '0;
    ready_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rot[i]) begin
        off = SLOT_W'(i);
        ready_found = 1'b1;
      end
    end
    idx_ext = {1'b0, start} + {1'b0, off};
    if (idx_ext >= (SLOT_W+1)'(NUM_SLOTS)) begin
      idx_ext = idx_ext - (SLOT_W+1)'(NUM_SLOTS);
    end
    ready_idx = idx_ext[SLOT_W-1:0];
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign pick = {free_found, free_idx, ready_found, ready_idx, reap_vec};

endmodule

[src/task_round_robin_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// task_round_robin_scheduler_unit
// round robin task scheduler over a table of task slots with saved contexts
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, context_req
//   rsp      out  valid/ready   status, resume_context, task_slot, freed_mask
//
// one request beat steps through accept, execute (slot table update and
// context write), context ram read and result load, in that order; the ram
// read data is registered, so the read follows the context write
// reset (sync, active high) frees all slots, clears the running task, the
// enable and the halt flag; context ram contents are left as they are
// a response waits in the output register; the next request is taken while
// it waits, and the result load stalls only until that register drains
// ----------------------------------------------------------------------------
module task_round_robin_scheduler_unit (
  input  logic             clk,
  input  logic             rst,
  trrs_req_if.sink         req,
  trrs_rsp_if.source       rsp
);
  import trrs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state;

  // captured request
  logic [OP_W-1:0]  op_q;
  logic [CTX_W-1:0] ctx_q;

  // scheduler state
  slot_st_t         st [NUM_SLOTS];
  slot_st_t         st_next [NUM_SLOTS];
  logic             run_valid, run_valid_next;
  slot_idx_t        run_idx, run_idx_next;
  logic             en, en_next;
  logic             halted, halted_next;

  // result of the execute step
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [CTX_W-1:0]    res_ctx, res_ctx_next;
  logic [TASK_W-1:0]   res_slot, res_slot_next;
  logic [MASK_W-1:0]   res_mask, res_mask_next;
  logic                use_mem, use_mem_next;
  slot_idx_t           rd_addr, rd_addr_next;

  // context ram access
  logic             mem_we;
  slot_idx_t        mem_waddr;
  logic [CTX_W-1:0] mem_rdata;

  // output register
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [CTX_W-1:0]         out_ctx;
  logic signed [TASK_W-1:0] out_slot;
  logic [MASK_W-1:0]        out_mask;
  logic                     out_free;

  pick_t            pick;
  logic [PAD_W-1:0] reap_pad;

  trrs_picker u_picker (
    .st        (st),
    .run_valid (run_valid),
    .run_idx   (run_idx),
    .incl_cur  (op_q == OP_SCHED),
    .pick      (pick)
  );

  trrs_ctx_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (CTX_W)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (mem_we && state == S_EXEC),
    .waddr (mem_waddr),
    .wdata (ctx_q),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;
  assign reap_pad  = PAD_W'(pick.reap_vec);

  // execute step: decide the slot table update and the result
  always_comb begin
    st_next         = st;
    run_valid_next  = run_valid;
    run_idx_next    = run_idx;
    en_next         = en;
    halted_next     = halted;
    res_status_next = STATUS_OK;
    res_ctx_next    = '0;
    res_slot_next   = TASK_NONE;
    res_mask_next   = '0;
    use_mem_next    = 1'b0;
    rd_addr_next    = '0;
    mem_we          = 1'b0;
    mem_waddr       = run_idx;

    if (halted) begin
      res_status_next = STATUS_HALTED;
    end else begin
      case (op_q)
        OP_SCHED, OP_EXIT: begin
          if (op_q == OP_EXIT && run_valid) begin
            st_next[run_idx] = ST_DEAD;
          end
          if (!en) begin
            if (op_q == OP_SCHED) begin
              // scheduling off: hand the caller's context straight back
              res_ctx_next  = ctx_q;
              res_slot_next = to_task_slot(run_valid, run_idx);
            end else begin
              halted_next     = 1'b1;
              res_status_next = STATUS_HALTED;
            end
          end else begin
            // save the caller's context, requeue a running task
            if (run_valid) begin
              mem_we = 1'b1;
              if (op_q == OP_SCHED && st[run_idx] == ST_RUN) begin
                st_next[run_idx] = ST_READY;
              end
            end
            if (pick.ready_found) begin
              run_valid_next          = 1'b1;
              run_idx_next            = pick.ready_idx;
              st_next[pick.ready_idx] = ST_RUN;
              use_mem_next            = 1'b1;
              rd_addr_next            = pick.ready_idx;
              res_slot_next           = to_task_slot(1'b1, pick.ready_idx);
            end else begin
              // nothing runnable: the block stops until reset
              halted_next     = 1'b1;
              res_status_next = STATUS_HALTED;
            end
          end
        end
        OP_CREATE: begin
          if (pick.free_found) begin
            mem_we                 = 1'b1;
            mem_waddr              = pick.free_idx;
            st_next[pick.free_idx] = ST_READY;
            res_slot_next          = to_task_slot(1'b1, pick.free_idx);
          end else begin
            res_status_next = STATUS_NO_FREE;
          end
        end
        OP_REAP: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pick.reap_vec[i]) begin
              st_next[i] = ST_FREE;
            end
          end
          res_mask_next = reap_pad[MASK_W-1:0];
        end
        OP_START: begin
          if (en) begin
            res_ctx_next  = ctx_q;
            res_slot_next = to_task_slot(run_valid, run_idx);
          end else if (pick.ready_found) begin
            run_valid_next          = 1'b1;
            run_idx_next            = pick.ready_idx;
            st_next[pick.ready_idx] = ST_RUN;
            en_next                 = 1'b1;
            use_mem_next            = 1'b1;
            rd_addr_next            = pick.ready_idx;
            res_slot_next           = to_task_slot(1'b1, pick.ready_idx);
          end else begin
            res_status_next = STATUS_NO_READY;
          end
        end
        default: begin
          // unused op: plain zeros, no task
        end
      endcase
    end
  end

  // control sequence and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      run_valid <= 1'b0;
      run_idx   <= '0;
      en        <= 1'b0;
      halted    <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st[i] <= ST_FREE;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          st        <= st_next;
          run_valid <= run_valid_next;
          run_idx   <= run_idx_next;
          en        <= en_next;
          halted    <= halted_next;
          state     <= S_READ;
        end
        S_READ: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and pending result, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op_q  <= req.op;
      ctx_q <= req.context_req;
    end
    if (state == S_EXEC) begin
      res_status <= res_status_next;
      res_ctx    <= res_ctx_next;
      res_slot   <= res_slot_next;
      res_mask   <= res_mask_next;
      use_mem    <= use_mem_next;
      rd_addr    <= rd_addr_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_status <= res_status;
      out_ctx    <= use_mem ? mem_rdata : res_ctx;
      out_slot   <= res_slot;
      out_mask   <= res_mask;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.resume_context = out_ctx;
  assign rsp.task_slot      = out_slot;
  assign rsp.freed_mask     = out_mask;

endmodule

[src/trrs_checker.sv]
// ----------------------------------------------------------------------------
// trrs_checker
// port level checks of the scheduler response channel
// ----------------------------------------------------------------------------
`include "task_round_robin_scheduler_unit_defines.svh"

module trrs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [trrs_pkg::STATUS_W-1:0] rsp_status,
  input logic [trrs_pkg::CTX_W-1:0]    rsp_resume_context,
  input logic [trrs_pkg::TASK_W-1:0]   rsp_task_slot,
  input logic [trrs_pkg::MASK_W-1:0]   rsp_freed_mask
);
  import trrs_pkg::*;

  logic seen_halt;

  // a delivered halt beat means every later beat is a halt too
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (rsp_valid && rsp_ready && rsp_status == STATUS_HALTED) begin
      seen_halt <= 1'b1;
    end
  end

  `TRRS_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped")

  `TRRS_ASSERT(a_fail_clean, clk, rst, rsp_valid && rsp_status != STATUS_OK |-> rsp_resume_context == '0 && rsp_task_slot == TASK_NONE && rsp_freed_mask == '0, "failure beat carries data")

  `TRRS_ASSERT_NEVER(a_mask_only_reap, clk, rst, rsp_valid && rsp_freed_mask != '0 && (rsp_status != STATUS_OK || rsp_task_slot != TASK_NONE), "freed mask outside reap")

  `TRRS_ASSERT(a_halt_sticky, clk, rst, rsp_valid && seen_halt |-> rsp_status == STATUS_HALTED, "beat after halt not halted")

endmodule

bind task_round_robin_scheduler_unit trrs_checker u_trrs_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_resume_context (rsp.resume_context),
  .rsp_task_slot      (rsp.task_slot),
  .rsp_freed_mask     (rsp.freed_mask)
);

[tb/tb_task_round_robin_scheduler_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_task_round_robin_scheduler_unit
// self-checking bench for the round robin task scheduler: a directed table of
// operations walks the empty, full and start-up corners, then random traffic
// creates, rotates, kills and reaps tasks under varying idle and stall
// patterns; every response beat is compared with a cycle-free model of the
// slot table, and the run ends by driving the block into its sticky halt
// ----------------------------------------------------------------------------
module tb_task_round_robin_scheduler_unit;
  import trrs_pkg::*;

  // op codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_BEATS = 1820;
  localparam int PHASE_BEATS  = RANDOM_BEATS / 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  // drain time after the last expected reply before the run ends
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CTX_W-1:0]    resume;
    logic [TASK_W-1:0]   slot;
    logic [MASK_W-1:0]   freed;
  } reply_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [CTX_W-1:0] ctx;
    bit               typed;
    reply_t           want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trrs_req_if req_ch ();
  trrs_rsp_if rsp_ch ();

  task_round_robin_scheduler_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // shadow copy of the slot table, current task and flags
  slot_st_t         tbl_state [NUM_SLOTS];
  logic [CTX_W-1:0] tbl_ctx [NUM_SLOTS];
  int               cur_slot;
  bit               sched_on;
  bit               stopped;

  reply_t due_replies [$];
  int     mismatches    = 0;
  int     quiet_cycles  = 0;
  int     snd_idle_pct  = 0;
  int     rcv_stall_pct = 0;
  bit     hold_request  = 1'b0;

  // slot number as the 5-bit task slot, all ones for no task
  function automatic logic [TASK_W-1:0] slot_code(input int s);
    return (s < 0) ? TASK_NONE : TASK_W'(s);
  endfunction

  // first ready slot after from, wrapping round to from itself last; -1 if none
  function automatic int next_ready(input int from);
    int idx;
    for (int i = 1; i <= NUM_SLOTS; i++) begin
      idx = (from + i + NUM_SLOTS) % NUM_SLOTS;
      if (tbl_state[idx] == ST_READY) return idx;
    end
    return -1;
  endfunction

  // save the caller's context and hand the cpu to the next ready task
  function automatic reply_t rotate_task(input logic [CTX_W-1:0] ctx);
    reply_t r;
    int     nxt;
    r.status = STATUS_OK;
    r.resume = '0;
    r.slot   = TASK_NONE;
    r.freed  = '0;
    if (cur_slot >= 0) begin
      tbl_ctx[cur_slot] = ctx;
      if (tbl_state[cur_slot] == ST_RUN) tbl_state[cur_slot] = ST_READY;
    end
    nxt = next_ready(cur_slot);
    if (nxt < 0) begin
      // nobody else ready: a live current task keeps going, else halt
      if (cur_slot >= 0 && tbl_state[cur_slot] != ST_DEAD) begin
        tbl_state[cur_slot] = ST_RUN;
        r.resume = tbl_ctx[cur_slot];
        r.slot   = slot_code(cur_slot);
      end else begin
        stopped  = 1'b1;
        r.status = STATUS_HALTED;
      end
      return r;
    end
    cur_slot       = nxt;
    tbl_state[nxt] = ST_RUN;
    r.resume       = tbl_ctx[nxt];
    r.slot         = slot_code(nxt);
    return r;
  endfunction

  // apply one operation to the shadow table and return the expected answer
  function automatic reply_t dispatch_outcome(input logic [OP_W-1:0] op,
                                              input logic [CTX_W-1:0] ctx);
    reply_t r;
    int     pick;
    r.status = STATUS_OK;
    r.resume = '0;
    r.slot   = TASK_NONE;
    r.freed  = '0;
    if (stopped) begin
      r.status = STATUS_HALTED;
      return r;
    end
    case (op)
      OP_SCHED: begin
        // before start the block just echoes the context back
        if (!sched_on) begin
          r.resume = ctx;
          r.slot   = slot_code(cur_slot);
        end else begin
          r = rotate_task(ctx);
        end
      end
      OP_CREATE: begin
        pick = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (pick < 0 && tbl_state[i] == ST_FREE) pick = i;
        if (pick < 0) begin
          r.status = STATUS_NO_FREE;
        end else begin
          tbl_ctx[pick]   = ctx;
          tbl_state[pick] = ST_READY;
          r.slot          = slot_code(pick);
        end
      end
      OP_EXIT: begin
        if (cur_slot >= 0) tbl_state[cur_slot] = ST_DEAD;
        if (!sched_on) begin
          stopped  = 1'b1;
          r.status = STATUS_HALTED;
        end else begin
          r = rotate_task(ctx);
        end
      end
      OP_REAP: begin
        // the current task is never reaped even when dead
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (i != cur_slot && tbl_state[i] == ST_DEAD) begin
            tbl_state[i] = ST_FREE;
            tbl_ctx[i]   = '0;
            if (i < MASK_W) r.freed[i] = 1'b1;
          end
        end
      end
      OP_START: begin
        if (sched_on) begin
          r.resume = ctx;
          r.slot   = slot_code(cur_slot);
        end else begin
          pick = next_ready(-1);
          if (pick < 0) begin
            r.status = STATUS_NO_READY;
          end else begin
            cur_slot        = pick;
            tbl_state[pick] = ST_RUN;
            sched_on        = 1'b1;
            r.resume        = tbl_ctx[pick];
            r.slot          = slot_code(pick);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic plan_row_t plan_row(input logic [OP_W-1:0] op,
                                         input logic [CTX_W-1:0] ctx,
                                         input bit typed,
                                         input logic [STATUS_W-1:0] st,
                                         input logic [CTX_W-1:0] res,
                                         input logic [TASK_W-1:0] sl,
                                         input logic [MASK_W-1:0] fm);
    plan_row_t p;
    p.op           = op;
    p.ctx          = ctx;
    p.typed        = typed;
    p.want.status  = st;
    p.want.resume  = res;
    p.want.slot    = sl;
    p.want.freed   = fm;
    return p;
  endfunction

  // offer one request beat, update the shadow table when it is taken;
  // entered and left at a falling edge, valid stays up for the next beat
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [CTX_W-1:0] ctx,
                           input bit typed, input reply_t want);
    reply_t got;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.context_req <= ctx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    got = dispatch_outcome(op, ctx);
    due_replies.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // response side: random back-pressure, plus one long hold on request
  initial begin : rsp_side
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_left   = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // compare every response beat with the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_replies.size() == 0) begin
        mismatches++;
        $display("%0t: response beat with nothing expected: status %h ctx %h slot %h mask %h",
                 $time, rsp_ch.status, rsp_ch.resume_context, rsp_ch.task_slot,
                 rsp_ch.freed_mask);
      end else begin
        want = due_replies.pop_front();
        if (rsp_ch.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %h got %h", $time, want.status, rsp_ch.status);
        end
        if (rsp_ch.resume_context !== want.resume) begin
          mismatches++;
          $display("%0t: resume_context expected %h got %h", $time, want.resume,
                   rsp_ch.resume_context);
        end
        if (rsp_ch.task_slot !== want.slot) begin
          mismatches++;
          $display("%0t: task_slot expected %h got %h", $time, want.slot,
                   rsp_ch.task_slot);
        end
        if (rsp_ch.freed_mask !== want.freed) begin
          mismatches++;
          $display("%0t: freed_mask expected %h got %h", $time, want.freed,
                   rsp_ch.freed_mask);
        end
      end
    end
  end

  // watchdog: too long without a beat on either channel means a hang
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t        plan [$];
    reply_t           blank;
    logic [OP_W-1:0]  op;
    logic [CTX_W-1:0] ctx;
    int               counted;
    int               total;
    int               r;
    int               ready_cnt;
    bit               lean;

    req_ch.valid       = 1'b0;
    req_ch.op          = OP_SCHED;
    req_ch.context_req = '0;
    blank              = '0;

    // shadow table after reset; saved contexts are left unknown on purpose
    foreach (tbl_state[i]) tbl_state[i] = ST_FREE;
    cur_slot = -1;
    sched_on = 1'b0;
    stopped  = 1'b0;

    // directed table: empty table corners, fill to full, start and rotate;
    // exit before start would halt for good, so it is left out here
    plan.push_back(plan_row(OP_SCHED, '1, 1, STATUS_OK, '1, TASK_NONE, '0));
    plan.push_back(plan_row(OP_START, 32'h1234_5678, 1, STATUS_NO_READY, '0,
                            TASK_NONE, '0));
    plan.push_back(plan_row(OP_REAP, 32'h0bad_f00d, 1, STATUS_OK, '0, TASK_NONE, '0));
    plan.push_back(plan_row(OP_SPARE_LO, '1, 1, STATUS_OK, '0, TASK_NONE, '0));
    plan.push_back(plan_row(OP_SPARE_HI, '0, 1, STATUS_OK, '0, TASK_NONE, '0));
    plan.push_back(plan_row(OP_CREATE, '0, 1, STATUS_OK, '0, 5'd0, '0));
    plan.push_back(plan_row(OP_CREATE, '1, 1, STATUS_OK, '0, 5'd1, '0));
    for (int i = 2; i < NUM_SLOTS; i++)
      plan.push_back(plan_row(OP_CREATE, 32'h4000_0000 + 32'(i) * 32'h0101_0101, 0,
                              STATUS_OK, '0, TASK_NONE, '0));
    // table full
    plan.push_back(plan_row(OP_CREATE, 32'h7777_7777, 1, STATUS_NO_FREE, '0,
                            TASK_NONE, '0));
    // start runs slot 0, a second start only echoes
    plan.push_back(plan_row(OP_START, 32'ha5a5_a5a5, 1, STATUS_OK, '0, 5'd0, '0));
    plan.push_back(plan_row(OP_START, 32'h5a5a_5a5a, 1, STATUS_OK, 32'h5a5a_5a5a,
                            5'd0, '0));
    plan.push_back(plan_row(OP_SCHED, 32'hdead_beef, 1, STATUS_OK, '1, 5'd1, '0));
    plan.push_back(plan_row(OP_EXIT, 32'h8000_0001, 0, STATUS_OK, '0, TASK_NONE, '0));
    plan.push_back(plan_row(OP_REAP, '0, 0, STATUS_OK, '0, TASK_NONE, '0));
    plan.push_back(plan_row(OP_CREATE, 32'h0000_ffff, 0, STATUS_OK, '0, TASK_NONE, '0));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i].op, plan[i].ctx, plan[i].typed, plan[i].want);

    // random traffic in four idling phases; the first one opens with a long
    // response hold so the request side backs up while beats keep coming
    total = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
          hold_request  = 1'b1;
        end
        1: begin
          snd_idle_pct  = 51;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 51;
        end
        default: begin
          snd_idle_pct  = 21;
          rcv_stall_pct = 21;
        end
      endcase
      counted = 0;
      while (counted < PHASE_BEATS) begin
        // every third stretch is lean on creates so the table drains and
        // the lone-task and empty-ready paths get exercised
        lean = ((total / 48) % 3) == 2;
        ready_cnt = 0;
        foreach (tbl_state[i]) if (tbl_state[i] == ST_READY) ready_cnt++;
        r = $urandom_range(99);
        if (r < 4)
          op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        else if (r < (lean ? 10 : 32))
          op = OP_CREATE;
        else if (r < 60)
          op = OP_SCHED;
        else if (r < 80)
          // only exit when another task can take over; halt is final
          op = (sched_on && ready_cnt > 0) ? OP_EXIT : OP_SCHED;
        else if (r < 94)
          op = OP_REAP;
        else
          op = OP_START;
        case ($urandom_range(9))
          0:       ctx = '0;
          1:       ctx = '1;
          default: ctx = $urandom;
        endcase
        send_beat(op, ctx, 1'b0, blank);
        total++;
        if (op < OP_SPARE_LO) counted++;
      end
    end

    // kill tasks until nothing is left to run, then poke the halted block
    while (!stopped) send_beat(OP_EXIT, $urandom, 1'b0, blank);
    repeat (6) send_beat(OP_W'($urandom_range(7)), $urandom, 1'b0, blank);
    req_ch.valid <= 1'b0;

    while (due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/trrs_pkg.sv
src/trrs_req_if.sv
src/trrs_rsp_if.sv
src/trrs_ctx_ram.sv
src/trrs_picker.sv
src/task_round_robin_scheduler_unit.sv
src/trrs_checker.sv
tb/tb_task_round_robin_scheduler_unit.sv
